/* design/stls_pkg.sv */
// ----------------------------------------------------------------------------
// stls_pkg
// Shared request and response types, function and status codes, and the
// sequencer state encoding for the slot table linked stack.
// ----------------------------------------------------------------------------
`default_nettype none

package stls_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] data_value;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_data;
    logic [3:0]  slot_index;
    logic [4:0]  element_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD_RD,
    ST_HEAD_WT,
    ST_WALK_RD,
    ST_WALK_WT,
    ST_UNLINK_P,
    ST_UNLINK_N,
    ST_ADD_LINK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* design/slot_table_linked_stack.sv */
// ----------------------------------------------------------------------------
// slot_table_linked_stack
// Table of slots holding a doubly linked list used as a stack with
// search and remove.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one response. An
// add scans the occupied marks for a free slot, one slot per cycle from the
// slot last added or popped, with wraparound. A peek reads the head through
// the HEAD_RD and HEAD_WT states; a pop also passes UNLINK_P and UNLINK_N. A
// remove walks the list from the head through the registered data and link
// memories, one WALK_RD and WALK_WT pair per node. An add on a full count
// goes straight to the done state, as do pop, peek and remove on an empty
// list. The finished response moves into a separate output register, so the
// next request can be taken even while that response waits; a second
// finished response holds the sequencer until the output register has been
// read.
`default_nettype none

module slot_table_linked_stack #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire stls_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output stls_pkg::rsp_t     out_data_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NullLink = LW'(CAPACITY);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  stls_pkg::state_e state_q, state_d;

  logic [CAPACITY-1:0] used_q, used_d;
  logic [LW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       last_q, last_d;

  stls_pkg::func_e       func_q, func_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [LW-1:0]         steps_q, steps_d;
  logic [LW-1:0]         pl_q, pl_d, nl_q, nl_d;

  logic                  rsp_valid_q, rsp_valid_d;
  stls_pkg::rsp_t        rsp_q, rsp_d;
  stls_pkg::rsp_t        out_rsp_q, out_rsp_d;

  // Memories: data, next links, previous links.
  logic                  d_we, n_we, p_we;
  logic [AW-1:0]         d_wa, n_wa, p_wa, rd_a;
  logic [DATA_WIDTH-1:0] d_wd, d_rd;
  logic [LW-1:0]         n_wd, p_wd, n_rd, p_rd;

  stls_ram #(.Width(DATA_WIDTH), .Depth(CAPACITY)) u_data (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(rd_a), .rdata_o(d_rd));
  stls_ram #(.Width(LW), .Depth(CAPACITY)) u_next (
    .clk_i(clk_i), .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd),
    .raddr_i(rd_a), .rdata_o(n_rd));
  stls_ram #(.Width(LW), .Depth(CAPACITY)) u_prev (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .raddr_i(rd_a), .rdata_o(p_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stls_pkg::ST_IDLE;
      used_q      <= '0;
      head_q      <= NullLink;
      tail_q      <= NullLink;
      count_q     <= '0;
      last_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      last_q      <= last_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    cur_q     <= cur_d;
    steps_q   <= steps_d;
    pl_q      <= pl_d;
    nl_q      <= nl_d;
    rsp_q     <= rsp_d;
    out_rsp_q <= out_rsp_d;
  end

  logic head_ok;
  logic [AW-1:0] cur_inc;
  logic [CW-1:0] count_dec;

  assign head_ok   = head_q < NullLink;
  assign cur_inc   = (cur_q == AW'(CAPACITY - 1)) ? '0 : cur_q + 1'b1;
  assign count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;

  assign in_ready_o  = (state_q == stls_pkg::ST_IDLE);
  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = out_rsp_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    last_d      = last_q;
    func_d      = func_q;
    val_d       = val_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    pl_d        = pl_q;
    nl_d        = nl_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    out_rsp_d   = out_rsp_q;
    d_we = 1'b0; d_wa = cur_q; d_wd = val_q;
    n_we = 1'b0; n_wa = cur_q; n_wd = head_q;
    p_we = 1'b0; p_wa = cur_q; p_wd = NullLink;
    rd_a = cur_q;

    if (rsp_valid_q && out_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      stls_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          func_d  = in_data_i.func;
          val_d   = in_data_i.data_value[DATA_WIDTH-1:0];
          cur_d   = last_q;
          steps_d = '0;
          rsp_d   = '0;
          unique case (in_data_i.func)
            stls_pkg::FUNC_ADD: begin
              if (count_q >= CapCount) begin
                rsp_d.status = stls_pkg::STATUS_FULL;
                state_d      = stls_pkg::ST_DONE;
              end else begin
                state_d = stls_pkg::ST_SCAN;
              end
            end
            stls_pkg::FUNC_POP, stls_pkg::FUNC_PEEK: begin
              if (!head_ok) begin
                rsp_d.status = stls_pkg::STATUS_EMPTY;
                state_d      = stls_pkg::ST_DONE;
              end else begin
                cur_d   = head_q[AW-1:0];
                state_d = stls_pkg::ST_HEAD_RD;
              end
            end
            default: begin
              if (!head_ok) begin
                rsp_d.status = stls_pkg::STATUS_NOT_FOUND;
                state_d      = stls_pkg::ST_DONE;
              end else begin
                cur_d   = head_q[AW-1:0];
                state_d = stls_pkg::ST_WALK_RD;
              end
            end
          endcase
        end
      end

      // One occupied mark examined per cycle.
      stls_pkg::ST_SCAN: begin
        if (!used_q[cur_q]) begin
          state_d = stls_pkg::ST_ADD_LINK;
        end else if (steps_q == LW'(CAPACITY - 1)) begin
          rsp_d.status = stls_pkg::STATUS_FULL;
          state_d      = stls_pkg::ST_DONE;
        end else begin
          cur_d   = cur_inc;
          steps_d = steps_q + 1'b1;
        end
      end

      stls_pkg::ST_ADD_LINK: begin
        d_we = 1'b1;
        n_we = 1'b1;
        p_we = 1'b1;
        used_d[cur_q] = 1'b1;
        head_d = LW'(cur_q);
        if (!(tail_q < NullLink)) begin
          tail_d = LW'(cur_q);
        end
        last_d  = cur_q;
        count_d = count_q + 1'b1;
        rsp_d.slot_index    = 4'(cur_q);
        rsp_d.element_count = 5'(count_q + 1'b1);
        if (head_ok) begin
          // Second write port use: old head gets its previous link next cycle.
          pl_d    = head_q;
          state_d = stls_pkg::ST_UNLINK_N;
          nl_d    = LW'(cur_q);
        end else begin
          state_d = stls_pkg::ST_DONE;
        end
      end

      stls_pkg::ST_HEAD_RD: begin
        state_d = stls_pkg::ST_HEAD_WT;
      end

      stls_pkg::ST_HEAD_WT: begin
        rsp_d.out_data = 32'(d_rd);
        if (func_q == stls_pkg::FUNC_POP) begin
          pl_d   = p_rd;
          nl_d   = n_rd;
          last_d = cur_q;
          state_d = stls_pkg::ST_UNLINK_P;
        end else begin
          rsp_d.element_count = 5'(count_q);
          state_d = stls_pkg::ST_DONE;
        end
      end

      stls_pkg::ST_WALK_RD: begin
        state_d = stls_pkg::ST_WALK_WT;
      end

      stls_pkg::ST_WALK_WT: begin
        if (d_rd == val_q) begin
          pl_d    = p_rd;
          nl_d    = n_rd;
          state_d = stls_pkg::ST_UNLINK_P;
        end else if (!(n_rd < NullLink) || steps_q == LW'(CAPACITY - 1)) begin
          rsp_d.status        = stls_pkg::STATUS_NOT_FOUND;
          rsp_d.element_count = 5'(count_q);
          state_d             = stls_pkg::ST_DONE;
        end else begin
          cur_d   = n_rd[AW-1:0];
          steps_d = steps_q + 1'b1;
          state_d = stls_pkg::ST_WALK_RD;
        end
      end

      // Unlink cur: next[p] = n here, prev[n] = p in the following state.
      stls_pkg::ST_UNLINK_P: begin
        if (pl_q < NullLink) begin
          n_we = 1'b1;
          n_wa = pl_q[AW-1:0];
          n_wd = nl_q;
        end
        p_we = 1'b1;
        p_wa = cur_q;
        p_wd = NullLink;
        used_d[cur_q] = 1'b0;
        count_d = count_dec;
        if (LW'(cur_q) == tail_q) tail_d = pl_q;
        if (LW'(cur_q) == head_q) head_d = nl_q;
        rsp_d.slot_index    = 4'(cur_q);
        rsp_d.element_count = 5'(count_dec);
        state_d = stls_pkg::ST_UNLINK_N;
      end

      stls_pkg::ST_UNLINK_N: begin
        if (func_q == stls_pkg::FUNC_ADD) begin
          p_we = 1'b1;
          p_wa = pl_q[AW-1:0];
          p_wd = nl_q;
        end else begin
          if (nl_q < NullLink) begin
            p_we = 1'b1;
            p_wa = nl_q[AW-1:0];
            p_wd = pl_q;
          end
          n_we = 1'b1;
          n_wa = cur_q;
          n_wd = NullLink;
        end
        state_d = stls_pkg::ST_DONE;
      end

      // Wait here while the output register still holds an unread response.
      stls_pkg::ST_DONE: begin
        if (!rsp_valid_q || out_ready_i) begin
          out_rsp_d = rsp_q;
          if (rsp_q.status != stls_pkg::STATUS_OK) begin
            out_rsp_d.element_count = 5'(count_q);
          end
          rsp_valid_d = 1'b1;
          state_d     = stls_pkg::ST_IDLE;
        end
      end

      default: state_d = stls_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/stls_ram.sv */
// ----------------------------------------------------------------------------
// stls_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stls_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
